### hdl/i2da_pkg.sv
// shared types and constants for the signed integer to decimal text converter
package i2da_pkg;

    localparam int MAG_W      = 32;
    localparam int N_DIGITS   = 10;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = $clog2(N_DIGITS);
    localparam int CHAR_W     = 7;
    localparam int N_DD_STG   = 8;
    localparam int DD_PER_STG = MAG_W / N_DD_STG;
    localparam int N_STG      = N_DD_STG + 1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    typedef logic signed [MAG_W-1:0]              t_value;
    typedef logic [MAG_W-1:0]                     t_mag;
    typedef logic [CHAR_W-1:0]                    t_char;
    typedef logic [N_DIGITS-1:0][DIGIT_W-1:0]     t_bcd;
    typedef logic [POS_W-1:0]                     t_pos;

    // one shift-and-add-3 working word: bcd digits over the binary remainder
    typedef struct packed {
        t_bcd bcd;
        t_mag bin;
    } t_dd;

endpackage

### hdl/i2da_if.sv
// request channels: signed integer in, ascii characters out
interface i2da_in_if;
    import i2da_pkg::*;
    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2da_out_if;
    import i2da_pkg::*;
    logic  valid;
    logic  ready;
    t_char character;
    logic  last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

### hdl/int32_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text, one character per request
// Each input request carries one signed 32-bit integer; the block returns its decimal
// text as one output request per character, most significant first, with a leading
// '-' for negative values and last_char set on the final character (1 to 11 characters).
// The conversion runs in a nine-stage pipeline (magnitude stage, then eight
// shift-and-add-3 stages of four bits each) ahead of the output serializer.
// Characters leave the serializer at one per cycle while o_out.ready is high; it
// holds one number at a time and so sets the sustained rate. The serializer loads
// the next number on the cycle its last character is taken, and the pipeline keeps
// accepting while it has free stages.
module int32_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2da_in_if.sink     i_in,
    i2da_out_if.source  o_out
);
    import i2da_pkg::*;

    // one double-dabble bit step
    function automatic t_dd dd_iter(input t_dd x);
        t_dd y;
        y = x;
        for (int d = 0; d < N_DIGITS; d++) begin
            if (y.bcd[d] >= 4'd5) begin
                y.bcd[d] = y.bcd[d] + 4'd3;
            end
        end
        y = t_dd'({y.bcd, y.bin} << 1);
        return y;
    endfunction

    // pipeline registers
    t_bcd             r_bcd [N_STG];
    t_mag             r_bin [N_STG];
    logic             r_neg [N_STG];
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_en;
    t_dd              n_dd  [N_DD_STG];

    // serializer registers
    t_bcd             r_sbcd;
    t_pos             r_spos;
    logic             r_sdash;
    logic             r_sbusy;

    logic             w_load;
    logic             w_last;
    logic             w_take;
    t_pos             w_msd;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[N_STG-1] = !r_vld[N_STG-1] || w_load;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    // four bit steps per conversion stage
    always_comb begin
        for (int k = 0; k < N_DD_STG; k++) begin
            n_dd[k] = '{bcd: r_bcd[k], bin: r_bin[k]};
            for (int j = 0; j < DD_PER_STG; j++) begin
                n_dd[k] = dd_iter(n_dd[k]);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_neg[0] <= i_in.value[MAG_W-1];
            r_bin[0] <= i_in.value[MAG_W-1] ? (t_mag'(0) - t_mag'(i_in.value))
                                            : t_mag'(i_in.value);
            r_bcd[0] <= '0;
        end
        for (int k = 1; k < N_STG; k++) begin
            if (w_en[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_bin[k] <= n_dd[k-1].bin;
                r_bcd[k] <= n_dd[k-1].bcd;
            end
        end
    end

    // leading digit position, zero gives position zero
    always_comb begin
        w_msd = '0;
        for (int d = 0; d < N_DIGITS; d++) begin
            if (r_bcd[N_STG-1][d] != 4'd0) begin
                w_msd = t_pos'(d);
            end
        end
    end

    assign w_last = !r_sdash && (r_spos == '0);
    assign w_take = r_sbusy && o_out.ready;
    assign w_load = r_vld[N_STG-1] && (!r_sbusy || (o_out.ready && w_last));

    // output serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdash <= 1'b0;
            r_spos  <= '0;
        end else if (w_load) begin
            r_sbusy <= 1'b1;
            r_sdash <= r_neg[N_STG-1];
            r_spos  <= w_msd;
        end else if (w_take) begin
            priority if (w_last) begin
                r_sbusy <= 1'b0;
            end else if (r_sdash) begin
                r_sdash <= 1'b0;
            end else begin
                r_spos <= r_spos - t_pos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sbcd <= r_bcd[N_STG-1];
        end
    end

    // output request
    assign o_out.valid     = r_sbusy;
    assign o_out.character = r_sdash ? ASCII_MINUS
                                     : ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_sbcd[r_spos]};
    assign o_out.last_char = w_last;

endmodule
